>>> sv/dda_pkg.sv
// Package for the DDA line rasteriser: widths, command codes and sequencer states.
// Depends on nothing; imported by dda_line_rasterizer_core.
package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    // accumulator: sign, integer part, fraction
    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    // increment: sign plus a magnitude of at most 1.0
    localparam int STEP_W = FRAC_BITS + 2;
    // quotient bits produced by one divide
    localparam int QUO_W  = FRAC_BITS + 1;
    // pixel count holds steps + 1
    localparam int CNT_W  = COORD_BITS + 1;
    // divide iteration counter, counts FRAC_BITS down to zero
    localparam int BIT_W  = $clog2(FRAC_BITS + 1);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } t_state;

endpackage

>>> sv/dda_line_rasterizer_core.sv
// DDA line rasteriser top level: start decode, shared serial divider, pixel stepper.
// Depends on dda_pkg for widths, command codes and sequencer states.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one beat per command.
//   A start beat (command 0) loads both endpoints and produces no output beat.
//   The block then stalls its input while one restoring divider, shared by both
//   axes, produces the x increment and then the y increment, one quotient bit
//   per cycle; no divide runs when the endpoints are equal (single-pixel line,
//   zero increments).
//   An advance beat (command 1) emits the current rounded pixel and steps the
//   accumulators; advance beats are taken one per cycle while the input is not
//   stalled, and each result is registered in the output stage. An advance with
//   no active line is absorbed silently. The final pixel carries o_last_pixel.
//   Output channel (o_out_valid / i_out_stall): a result register plus a skid
//   register; while the receiver stalls, one further advance is still taken
//   into the skid stage, after which the input stalls until the skid drains.
//   A start beat arriving during a line drops that line.
//   Reset (i_rst_n low, synchronous) clears the sequencer, the line and both
//   output stages.
module dda_line_rasterizer_core
    import dda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

    t_state r_state, n_state;

    // line state
    logic [ACC_W-1:0]      r_acc_x, r_acc_y;
    logic [STEP_W-1:0]     r_step_x, r_step_y;
    logic [CNT_W-1:0]      r_pixels_left;
    logic                  r_line_active;

    // divider state
    logic [COORD_BITS-1:0] r_steps;
    logic [COORD_BITS-1:0] r_mag_y;
    logic                  r_sign_x, r_sign_y;
    logic [COORD_BITS:0]   r_rem;
    logic [QUO_W-1:0]      r_quo;
    logic [BIT_W-1:0]      r_bit_cnt;

    // output stages
    logic                  r_out_valid, r_skid_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic                  r_out_last, r_skid_last;

    logic                  in_accept, start_beat, adv_beat, res_valid;
    logic                  x_neg, y_neg;
    logic [COORD_BITS-1:0] mag_x, mag_y, steps;
    logic [ACC_W-1:0]      round_x, round_y;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic                  res_last;
    logic                  div_ge, div_last;
    logic [COORD_BITS:0]   div_diff;
    logic [COORD_BITS-1:0] div_keep;
    logic [QUO_W-1:0]      quo_done;
    logic [STEP_W-1:0]     step_done;
    logic                  out_free;

    assign o_in_stall = (r_state != ST_IDLE) | r_skid_valid;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign start_beat = in_accept & (i_command == CMD_START);
    assign adv_beat   = in_accept & (i_command == CMD_ADVANCE);
    assign res_valid  = adv_beat & r_line_active;

    // endpoint deltas: sign and magnitude per axis, step count is the larger
    assign x_neg = i_end_x < i_start_x;
    assign y_neg = i_end_y < i_start_y;
    assign mag_x = x_neg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign mag_y = y_neg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
    assign steps = (mag_x > mag_y) ? mag_x : mag_y;

    // round half up, keep the coordinate bits
    assign round_x  = r_acc_x + HALF_LSB;
    assign round_y  = r_acc_y + HALF_LSB;
    assign res_x    = round_x[FRAC_BITS +: COORD_BITS];
    assign res_y    = round_y[FRAC_BITS +: COORD_BITS];
    assign res_last = (r_pixels_left == CNT_W'(1));

    // shared restoring divide step: one compare-subtract per cycle
    assign div_diff  = r_rem - {1'b0, r_steps};
    assign div_ge    = (r_rem >= {1'b0, r_steps});
    assign div_keep  = div_ge ? div_diff[COORD_BITS-1:0] : r_rem[COORD_BITS-1:0];
    assign div_last  = (r_bit_cnt == '0);
    assign quo_done  = {r_quo[QUO_W-2:0], div_ge};
    assign step_done = (r_state == ST_DIV_X ? r_sign_x : r_sign_y)
                     ? STEP_W'(-{1'b0, quo_done}) : {1'b0, quo_done};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_beat && steps != '0) begin
                    n_state = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_last) begin
                    n_state = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // line control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_pixels_left <= '0;
        end else if (start_beat) begin
            r_line_active <= 1'b1;
            r_pixels_left <= CNT_W'(steps) + CNT_W'(1);
        end else if (res_valid) begin
            r_pixels_left <= r_pixels_left - CNT_W'(1);
            if (res_last) begin
                r_line_active <= 1'b0;
            end
        end
    end

    // accumulators, increments and divider datapath
    always_ff @(posedge i_clk) begin
        if (start_beat) begin
            r_acc_x   <= ACC_W'(i_start_x) << FRAC_BITS;
            r_acc_y   <= ACC_W'(i_start_y) << FRAC_BITS;
            r_step_x  <= '0;
            r_step_y  <= '0;
            r_steps   <= steps;
            r_mag_y   <= mag_y;
            r_sign_x  <= x_neg;
            r_sign_y  <= y_neg;
            r_rem     <= {1'b0, mag_x};
            r_quo     <= '0;
            r_bit_cnt <= BIT_W'(FRAC_BITS);
        end else if (r_state != ST_IDLE) begin
            r_quo     <= quo_done;
            r_rem     <= {div_keep, 1'b0};
            r_bit_cnt <= r_bit_cnt - BIT_W'(1);
            if (div_last) begin
                // reload the divider with the y axis operands and store the finished increment
                r_quo     <= '0;
                r_rem     <= {1'b0, r_mag_y};
                r_bit_cnt <= BIT_W'(FRAC_BITS);
                if (r_state == ST_DIV_X) begin
                    r_step_x <= step_done;
                end else begin
                    r_step_y <= step_done;
                end
            end
        end else if (res_valid) begin
            r_acc_x <= r_acc_x + {{(ACC_W-STEP_W){r_step_x[STEP_W-1]}}, r_step_x};
            r_acc_y <= r_acc_y + {{(ACC_W-STEP_W){r_step_y[STEP_W-1]}}, r_step_y};
        end
    end

    // output register and skid stage
    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_x    <= r_skid_x;
                r_out_y    <= r_skid_y;
                r_out_last <= r_skid_last;
            end else if (res_valid) begin
                r_out_x    <= res_x;
                r_out_y    <= res_y;
                r_out_last <= res_last;
            end
        end else if (res_valid) begin
            r_skid_x    <= res_x;
            r_skid_y    <= res_y;
            r_skid_last <= res_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_last_pixel = r_out_last;

    // the divider never runs while the input is open
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input open while divider busy");

    // skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage filled ahead of output register");

    // an active line always has a pixel left
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_pixels_left != '0))
        else $error("active line with no pixels left");

    // the y divide ends the sequence
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_Y && div_last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after y divide");

    // the output register holds a valid beat the cycle after an advance result
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> r_out_valid)
        else $error("advance result lost");

endmodule
